### rtl/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared widths, status codes and structs for the UTF-8 byte stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned RemW  = 2;

  typedef enum logic [1:0] {
    ST_CHAR     = 2'd0,
    ST_END      = 2'd1,
    ST_BAD_LEAD = 2'd2,
    ST_BAD_CONT = 2'd3
  } status_e;

  // One decoded result as it leaves the step logic.
  typedef struct packed {
    logic             emit;
    logic [CpW-1:0]   code_point;
    status_e          status;
  } result_t;

  // Decoder state, exported for checking.
  typedef struct packed {
    logic [RemW-1:0]  remaining;
    logic [CpW-1:0]   acc;
    logic             halted;
  } dec_state_t;

endpackage

### rtl/utf8d_step.sv
// ----------------------------------------------------------------------------
// utf8d_step
// Decoder state registers and the per-byte next-state and result logic.
// ----------------------------------------------------------------------------
module utf8d_step
  import utf8d_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  logic [ByteW-1:0] data_byte_i,
  output result_t          res_o,
  output dec_state_t       state_o
);

  dec_state_t state_q, state_d;
  result_t    res;

  always_comb begin
    logic [CpW-1:0] shifted;
    shifted = {state_q.acc[CpW-7:0], data_byte_i[5:0]};
    state_d = state_q;
    res.emit       = 1'b0;
    res.code_point = '0;
    res.status     = ST_CHAR;

    if (state_q.halted) begin
      // Bytes are dropped until the string terminator.
      if (data_byte_i == '0) begin
        state_d.halted = 1'b0;
      end
    end else if (state_q.remaining != '0) begin
      if (data_byte_i[7:6] == 2'b10) begin
        state_d.remaining = state_q.remaining - 1'b1;
        if (state_q.remaining == RemW'(1)) begin
          res.emit       = 1'b1;
          res.code_point = shifted;
          state_d.acc    = '0;
        end else begin
          state_d.acc = shifted;
        end
      end else begin
        // A zero byte here ends the string as well, so no halt follows.
        res.emit          = 1'b1;
        res.code_point    = state_q.acc;
        res.status        = ST_BAD_CONT;
        state_d.acc       = '0;
        state_d.remaining = '0;
        state_d.halted    = (data_byte_i != '0);
      end
    end else if (data_byte_i == '0) begin
      res.emit   = 1'b1;
      res.status = ST_END;
    end else if (data_byte_i[7] == 1'b0) begin
      res.emit       = 1'b1;
      res.code_point = CpW'(data_byte_i);
    end else if (data_byte_i inside {[8'hF0:8'hFF]}) begin
      state_d.acc       = CpW'(data_byte_i[2:0]);
      state_d.remaining = RemW'(3);
    end else if (data_byte_i inside {[8'hE0:8'hEF]}) begin
      state_d.acc       = CpW'(data_byte_i[3:0]);
      state_d.remaining = RemW'(2);
    end else if (data_byte_i inside {[8'hC0:8'hDF]}) begin
      state_d.acc       = CpW'(data_byte_i[4:0]);
      state_d.remaining = RemW'(1);
    end else begin
      res.emit       = 1'b1;
      res.status     = ST_BAD_LEAD;
      state_d.acc    = '0;
      state_d.halted = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance_i) begin
      state_q <= state_d;
    end
  end

  assign res_o   = res;
  assign state_o = state_q;

endmodule

### rtl/utf8d_out_reg.sv
// ----------------------------------------------------------------------------
// utf8d_out_reg
// Result register that holds one item until the downstream side takes it.
// ----------------------------------------------------------------------------
module utf8d_out_reg
  import utf8d_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  result_t        res_i,
  input  logic           out_stall_i,
  output logic           free_o,
  output logic           out_valid_o,
  output logic [CpW-1:0] code_point_o,
  output logic [1:0]     status_o
);

  logic           valid_q;
  logic [CpW-1:0] cp_q;
  status_e        status_q;

  assign free_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      cp_q     <= res_i.code_point;
      status_q <= res_i.status;
    end
  end

  assign out_valid_o  = valid_q;
  assign code_point_o = cp_q;
  assign status_o     = status_q;

endmodule

### rtl/utf8_byte_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder_unit
// Lenient UTF-8 decoder: one byte in per item, zero or one code point out.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Handshake               | Payload
//  ---------+-----+-------------------------+---------------------------------
//  in       | in  | in_valid_i / in_stall_o | data_byte_i[7:0]
//  out      | out | out_valid_o/out_stall_i | code_point_o[20:0], status_o[1:0]
//
// One byte is taken every cycle while in_stall_o is low; a result is offered once
// its byte has passed the input register and the result register has caught it.
// Throughput is bounded only by the single result register draining.
// Reset clears the decoder state and both valid flags.
// A byte that gives no result moves on even while a result waits stalled.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder_unit
  import utf8d_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] data_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [CpW-1:0]   code_point_o,
  output logic [1:0]       status_o
);

  logic             in_valid_q;
  logic [ByteW-1:0] byte_q;
  logic             advance;
  logic             out_free;
  result_t          res;
  dec_state_t       dec_state;

  assign advance    = in_valid_q && (out_free || !res.emit);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q <= data_byte_i;
    end
  end

  utf8d_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .data_byte_i (byte_q),
    .res_o       (res),
    .state_o     (dec_state)
  );

  utf8d_out_reg u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (advance && res.emit),
    .res_i        (res),
    .out_stall_i  (out_stall_i),
    .free_o       (out_free),
    .out_valid_o  (out_valid_o),
    .code_point_o (code_point_o),
    .status_o     (status_o)
  );

  // Back-pressure upstream only ever comes from a held result downstream.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without downstream back-pressure");

  // A halted decoder never produces a result.
  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && dec_state.halted) |-> !res.emit)
    else $error("result produced while halted");

  // A bad lead byte leaves the decoder halted with nothing pending.
  a_bad_lead_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res.emit && res.status == ST_BAD_LEAD)
      |=> (dec_state.halted && dec_state.remaining == '0))
    else $error("bad lead byte did not halt the decoder");

  // An accepted result that still needs bytes cannot exist.
  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res.emit) |=> (dec_state.remaining == '0 && dec_state.acc == '0))
    else $error("state not cleared after a result");

endmodule
